>>> hdl/murmur3_32_hash_defines.svh
// ----------------------------------------------------------------------------
// MurmurHash3 x86_32 stream hasher: assertion macros
// Shared concurrent assertion forms; defining ASSERT_OFF leaves them empty.
// ----------------------------------------------------------------------------
`ifndef MURMUR3_32_HASH_DEFINES_SVH
`define MURMUR3_32_HASH_DEFINES_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled while reset is asserted.
`define MM3_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define MM3_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`else

`define MM3_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define MM3_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

>>> hdl/mm3_pkg.sv
// ----------------------------------------------------------------------------
// MurmurHash3 x86_32 package
// Constants, queue item type, status type and bit helpers shared by the hasher.
// ----------------------------------------------------------------------------
package mm3_pkg;

    // Mixing and finalization constants of the algorithm.
    localparam logic [31:0] MM3_C1 = 32'hcc9e2d51;
    localparam logic [31:0] MM3_C2 = 32'h1b873593;
    localparam logic [31:0] MM3_N  = 32'he6546b64;
    localparam logic [31:0] MM3_F1 = 32'h85ebca6b;
    localparam logic [31:0] MM3_F2 = 32'hc2b2ae35;

    // Byte count of a whole block.
    localparam logic [2:0] MM3_BYTES_FULL = 3'd4;

    // Default depth of the queue between front and back (at least 2).
    localparam int MM3_QDEPTH = 4;

    // Register map.
    localparam int          MM3_ADDR_W    = 2;
    localparam logic [1:0]  MM3_ADDR_SEED = 2'd0;

    // One scrambled word on its way from front to back.
    typedef struct packed {
        logic [31:0] k;     // scrambled key (masked for a tail)
        logic [2:0]  cnt;   // bytes this item adds, 0 to 4
        logic        last;  // final item of its message
    } t_mm3_item;

    // Back-end status seen by the top level.
    typedef struct packed {
        logic pop;       // an item leaves the queue this cycle
        logic fin_busy;  // a hash is being finalized or waits at the output
    } t_mm3_back_sts;

    function automatic logic [31:0] mm3_rotl15(input logic [31:0] x);
        return {x[16:0], x[31:17]};
    endfunction

    function automatic logic [31:0] mm3_rotl13(input logic [31:0] x);
        return {x[18:0], x[31:19]};
    endfunction

    // Keeps the low cnt bytes of a word; a count of four keeps all of it.
    function automatic logic [31:0] mm3_byte_mask(input logic [2:0] cnt);
        logic [31:0] m;
        m = ~({32{1'b1}} << {cnt[1:0], 3'b000});
        if (cnt == MM3_BYTES_FULL) begin
            m = {32{1'b1}};
        end
        return m;
    endfunction

endpackage

>>> hdl/mm3_front.sv
// ----------------------------------------------------------------------------
// MurmurHash3 front end
// Accepts input items, settles their byte count, masks tail bytes and runs
// the two-multiply key scramble over two registered stages into the queue.
// ----------------------------------------------------------------------------
module mm3_front #(
    parameter int DEPTH = mm3_pkg::MM3_QDEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [31:0]                    i_data_word,
    input  logic [2:0]                     i_byte_count,
    input  logic                           i_last,
    input  logic [$clog2(DEPTH+1)-1:0]     i_q_count,
    output logic                           o_push,
    output mm3_pkg::t_mm3_item             o_item,
    output logic [1:0]                     o_pipe_cnt
);
    import mm3_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W:0] DEPTH_L = (CNT_W + 1)'(DEPTH);

    logic               w_accept;
    logic [2:0]         w_cnt;
    logic [31:0]        w_masked;
    logic [CNT_W:0]     w_occupancy;

    logic               r_s1_v;
    logic [31:0]        r_s1_prod;
    logic [2:0]         r_s1_cnt;
    logic               r_s1_last;
    logic               r_s2_v;
    t_mm3_item          r_s2_item;

    // Items in the two stages plus the queue never exceed the queue depth,
    // so a pushed item always finds room.
    assign w_occupancy = {1'b0, i_q_count} + (CNT_W + 1)'(r_s1_v) + (CNT_W + 1)'(r_s2_v);
    assign o_ready     = (w_occupancy < DEPTH_L);
    assign w_accept    = i_valid && o_ready;

    // A non-last item is always a whole block; a last one saturates at four.
    always_comb begin
        if (!i_last || (i_byte_count > MM3_BYTES_FULL)) begin
            w_cnt = MM3_BYTES_FULL;
        end else begin
            w_cnt = i_byte_count;
        end
    end

    assign w_masked = i_data_word & mm3_byte_mask(w_cnt);

    // Stage valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            r_s1_v <= w_accept;
            r_s2_v <= r_s1_v;
        end
    end

    // First multiply of the scramble.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_prod <= w_masked * MM3_C1;
            r_s1_cnt  <= w_cnt;
            r_s1_last <= i_last;
        end
    end

    // Rotate and second multiply.
    always_ff @(posedge i_clk) begin
        if (r_s1_v) begin
            r_s2_item.k    <= mm3_rotl15(r_s1_prod) * MM3_C2;
            r_s2_item.cnt  <= r_s1_cnt;
            r_s2_item.last <= r_s1_last;
        end
    end

    assign o_push     = r_s2_v;
    assign o_item     = r_s2_item;
    assign o_pipe_cnt = 2'(r_s1_v) + 2'(r_s2_v);

endmodule

>>> hdl/mm3_fifo.sv
// ----------------------------------------------------------------------------
// MurmurHash3 item queue
// Small first-in first-out buffer of scrambled items between front and back.
// ----------------------------------------------------------------------------
module mm3_fifo #(
    parameter int DEPTH = mm3_pkg::MM3_QDEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    input  mm3_pkg::t_mm3_item             i_item,
    input  logic                           i_pop,
    output logic                           o_valid,
    output mm3_pkg::t_mm3_item             o_item,
    output logic [$clog2(DEPTH+1)-1:0]     o_count
);
    import mm3_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    t_mm3_item          r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;

    // Storage, written at the write pointer.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    // Fill count follows pushes and pops.
    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    // Pointers wrap at the depth.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
        end
    end

    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign o_count = r_count;

endmodule

>>> hdl/mm3_back.sv
// ----------------------------------------------------------------------------
// MurmurHash3 back end
// Runs the hash recurrence on queued items, tracks the byte length, and
// finalizes a message through a registered avalanche into the output register.
// ----------------------------------------------------------------------------
module mm3_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [31:0]            i_seed,
    input  logic                   i_q_valid,
    input  mm3_pkg::t_mm3_item     i_q_item,
    output logic                   o_pop,
    output mm3_pkg::t_mm3_back_sts o_sts,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [31:0]            o_hash_value
);
    import mm3_pkg::*;

    logic           w_fin_busy;
    logic [31:0]    w_base_h;
    logic [31:0]    w_base_len;
    logic [31:0]    w_rot;
    logic [31:0]    w_mixed;
    logic [31:0]    w_h1;
    logic [31:0]    w_len1;
    logic [31:0]    w_x;
    logic [31:0]    w_a;
    logic [31:0]    w_b;

    logic           r_in_msg;
    logic [31:0]    r_hash;
    logic [31:0]    r_len;
    logic           r_f0_v;
    logic           r_f1_v;
    logic           r_f2_v;
    logic           r_out_v;
    logic [31:0]    r_fin_h;
    logic [31:0]    r_fin_len;
    logic [31:0]    r_f1_p;
    logic [31:0]    r_f2_p;
    logic [31:0]    r_out;

    // Only one message is finalized at a time; a last item waits for it.
    assign w_fin_busy = r_f0_v || r_f1_v || r_f2_v || r_out_v;
    assign o_pop      = i_q_valid && (!i_q_item.last || !w_fin_busy);

    // A new message starts from the seed and a zero length.
    assign w_base_h   = r_in_msg ? r_hash : i_seed;
    assign w_base_len = r_in_msg ? r_len : '0;

    // Block step: rotate, then times five plus the constant.
    assign w_rot   = mm3_rotl13(w_base_h ^ i_q_item.k);
    assign w_mixed = w_rot + {w_rot[29:0], 2'b00} + MM3_N;

    // A whole block mixes fully, a tail only XORs in, an empty tail adds nothing.
    always_comb begin
        if (i_q_item.cnt == MM3_BYTES_FULL) begin
            w_h1 = w_mixed;
        end else if (i_q_item.cnt == 3'd0) begin
            w_h1 = w_base_h;
        end else begin
            w_h1 = w_base_h ^ i_q_item.k;
        end
    end

    assign w_len1 = w_base_len + 32'(i_q_item.cnt);

    // Message tracking and finalization valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_msg <= 1'b0;
            r_f0_v   <= 1'b0;
            r_f1_v   <= 1'b0;
            r_f2_v   <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (o_pop) begin
                r_in_msg <= !i_q_item.last;
            end
            r_f0_v <= o_pop && i_q_item.last;
            r_f1_v <= r_f0_v;
            r_f2_v <= r_f1_v;
            if (r_f2_v) begin
                r_out_v <= 1'b1;
            end else if (i_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // Running hash and length, or the values handed to finalization.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            if (i_q_item.last) begin
                r_fin_h   <= w_h1;
                r_fin_len <= w_len1;
            end else begin
                r_hash <= w_h1;
                r_len  <= w_len1;
            end
        end
    end

    // Avalanche: one multiply in each of the F1 and F2 stages, none in the output stage.
    assign w_x = r_fin_h ^ r_fin_len;
    assign w_a = w_x ^ (w_x >> 16);
    assign w_b = r_f1_p ^ (r_f1_p >> 13);

    always_ff @(posedge i_clk) begin
        if (r_f0_v) begin
            r_f1_p <= w_a * MM3_F1;
        end
        if (r_f1_v) begin
            r_f2_p <= w_b * MM3_F2;
        end
        if (r_f2_v) begin
            r_out <= r_f2_p ^ (r_f2_p >> 16);
        end
    end

    assign o_valid      = r_out_v;
    assign o_hash_value = r_out;
    assign o_sts.pop      = o_pop;
    assign o_sts.fin_busy = w_fin_busy;

endmodule

>>> hdl/murmur3_32_hash.sv
// Usage: MurmurHash3 x86_32 over a stream of little-endian 32-bit words.
// Input channel: i_valid/o_ready with i_data_word, i_byte_count and i_last.
// Each non-last item is one whole four-byte block; the last item carries 0 to
// 4 valid bytes (larger counts act as 4). Output channel: o_valid/i_ready with
// o_hash_value, one item per message. The seed register at address 0 of the
// APB port is loaded at the start of each message; write it only while idle.
// Throughput: one input item per cycle while o_ready stays high, set by the
// two-stage scramble in the front end feeding the hash recurrence in the
// back end. After its last item is accepted, the hash passes the front
// stages, the queue and the registered avalanche into the output register.
// One message is finalized at a time, so a last item waits in the queue
// until the previous hash is taken.
// Reset clears the queue, the pipelines and the message state; the seed
// returns to zero. When the receiver stalls, the hash holds at the output,
// the queue fills and o_ready drops once QUEUE_DEPTH items are in flight.
// ----------------------------------------------------------------------------
// MurmurHash3 x86_32 stream hasher, top level
// Configuration port, front end, item queue and back end with assertions.
// ----------------------------------------------------------------------------
`include "murmur3_32_hash_defines.svh"

module murmur3_32_hash #(
    parameter int QUEUE_DEPTH = mm3_pkg::MM3_QDEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mm3_pkg::MM3_ADDR_W-1:0]  paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    // Input channel
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [31:0]                     i_data_word,
    input  logic [2:0]                      i_byte_count,
    input  logic                            i_last,
    // Output channel
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [31:0]                     o_hash_value
);
    import mm3_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W:0] DEPTH_L = (CNT_W + 1)'(QUEUE_DEPTH);

    logic [31:0]        r_seed;
    logic               w_cfg_wr;
    logic               w_push;
    t_mm3_item          w_push_item;
    logic [1:0]         w_pipe_cnt;
    logic               w_q_valid;
    t_mm3_item          w_q_item;
    logic [CNT_W-1:0]   w_q_count;
    logic               w_pop;
    t_mm3_back_sts      w_back_sts;
    logic [CNT_W:0]     w_inflight;

    // Seed register.
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready && (paddr == MM3_ADDR_SEED);
    assign prdata   = (paddr == MM3_ADDR_SEED) ? r_seed : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= '0;
        end else if (w_cfg_wr) begin
            r_seed <= pwdata;
        end
    end

    mm3_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_data_word  (i_data_word),
        .i_byte_count (i_byte_count),
        .i_last       (i_last),
        .i_q_count    (w_q_count),
        .o_push       (w_push),
        .o_item       (w_push_item),
        .o_pipe_cnt   (w_pipe_cnt)
    );

    mm3_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_item  (w_q_item),
        .o_count (w_q_count)
    );

    mm3_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_seed       (r_seed),
        .i_q_valid    (w_q_valid),
        .i_q_item     (w_q_item),
        .o_pop        (w_pop),
        .o_sts        (w_back_sts),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_hash_value (o_hash_value)
    );

    // Items held in the front stages and the queue together.
    assign w_inflight = {1'b0, w_q_count} + (CNT_W + 1)'(w_pipe_cnt);

    // The front end never overfills the queue.
    `MM3_ASSERT_IMP(a_no_overfill, i_clk, i_rst_n, 1'b1, w_inflight <= DEPTH_L)
    // A last item leaves the queue only when no hash is being finalized.
    `MM3_ASSERT_IMP(a_one_final, i_clk, i_rst_n, w_back_sts.pop && w_q_item.last,
                    !w_back_sts.fin_busy)
    // The back end pops only items that are there.
    `MM3_ASSERT_IMP(a_pop_valid, i_clk, i_rst_n, w_back_sts.pop, w_q_valid)
    // Popping a last item starts finalization in the next cycle.
    `MM3_ASSERT_NXT(a_fin_start, i_clk, i_rst_n, w_back_sts.pop && w_q_item.last,
                    w_back_sts.fin_busy)

endmodule
